FILE: design/marked_block_deframer_defines.svh
// Assertion macros for the marked block deframer.
`ifndef MARKED_BLOCK_DEFRAMER_DEFINES_SVH
`define MARKED_BLOCK_DEFRAMER_DEFINES_SVH

`ifndef SYNTH
`define MBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
`define MBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle");
`else
`define MBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define MBD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/mbd_pkg.sv
// Types and constants for the marked block deframer.
package mbd_pkg;

    localparam int unsigned POS_W      = 25;
    localparam int unsigned LIMIT_W    = 25;
    localparam int unsigned HDR_BYTES  = 16;
    localparam int unsigned OVERHEAD   = 24;
    localparam int unsigned MARK_BYTES = 8;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 25'd65536;

    // Register index taken from paddr[2] (byte address 4*i)
    localparam logic REG_MAX_BLOCK = 1'b0;

    localparam logic [7:0] START_MARK [MARK_BYTES] = '{
        8'hAA, 8'hD6, 8'h3E, 8'h69, 8'h02, 8'h5A, 8'h7F, 8'h55
    };
    localparam logic [7:0] END_MARK [MARK_BYTES] = '{
        8'h55, 8'h7F, 8'h5A, 8'h02, 8'h69, 8'h3E, 8'hD6, 8'hAA
    };

    typedef enum logic [2:0] {
        KIND_PAYLOAD   = 3'd0,
        KIND_OK        = 3'd1,
        KIND_BAD_START = 3'd2,
        KIND_TOO_BIG   = 3'd3,
        KIND_BAD_END   = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic        seq_warn;
        logic [31:0] block_seq;
        logic        last;
    } result_t;

endpackage

FILE: design/marked_block_deframer.sv
// Marked block deframer: header check, payload pass-through, end marker status.
// Results on m_* are registered: in the output register, or first in the skid register while m_ready stalls the output.
// Throughput: one byte per cycle while s_ready is high, set by one pass of position compare and register updates.
// A skid register holds one more result while a result is stalled on m_ready.
// Reset (aresetn, synchronous, active low) returns to header hunting at byte 0,
// sets the limit to 65536 and the last good sequence number to 0.
`include "marked_block_deframer_defines.svh"

module marked_block_deframer (
    input  logic                aclk,
    input  logic                aresetn,
    // config
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // input bytes
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_in_byte,
    // results
    output logic                m_valid,
    input  logic                m_ready,
    output mbd_pkg::kind_t      m_kind,
    output logic [7:0]          m_payload_byte,
    output logic                m_seq_warn,
    output logic [31:0]         m_block_seq,
    output logic                m_last
);
    import mbd_pkg::*;

    logic [LIMIT_W-1:0] max_block_reg;

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               start_ok_reg, start_ok_next;
    logic [31:0]        len_reg, len_next;
    logic [31:0]        seq_reg, seq_next;
    logic [POS_W-1:0]   end_start_reg, end_start_next;
    logic [POS_W-1:0]   last_pos_reg, last_pos_next;
    logic [31:0]        last_good_reg, last_good_next;
    logic               end_ok_reg, end_ok_next;
    logic               warn_reg, warn_next;

    logic               out_valid_reg;
    result_t            out_reg;
    logic               skid_valid_reg;
    result_t            skid_reg;

    logic               accept;
    logic               res_valid;
    result_t            res;
    logic [31:0]        seq_cur;
    logic [32:0]        total;
    logic               warn_cur;
    logic               end_ok_cur;
    logic [2:0]         end_idx;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_block_reg <= LIMIT_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_MAX_BLOCK) begin
            max_block_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_MAX_BLOCK) begin
            prdata = {{(32-LIMIT_W){1'b0}}, max_block_reg};
        end else begin
            prdata = 32'd0;
        end
    end

    // ------------------------------------------------------------------
    // Per-byte step
    // ------------------------------------------------------------------
    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;

    assign seq_cur  = {seq_reg[23:0], s_in_byte};
    assign total    = {1'b0, len_reg} + 33'(OVERHEAD);
    assign warn_cur = seq_cur != (last_good_reg + 32'd1);
    assign end_idx  = pos_reg[2:0] - end_start_reg[2:0];
    assign end_ok_cur = end_ok_reg && (s_in_byte == END_MARK[end_idx]);

    always_comb begin
        pos_next       = pos_reg;
        start_ok_next  = start_ok_reg;
        len_next       = len_reg;
        seq_next       = seq_reg;
        end_start_next = end_start_reg;
        last_pos_next  = last_pos_reg;
        last_good_next = last_good_reg;
        end_ok_next    = end_ok_reg;
        warn_next      = warn_reg;
        res_valid      = 1'b0;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = 8'd0;
        res.seq_warn     = warn_reg;
        res.block_seq    = seq_reg;
        res.last         = 1'b0;

        if (pos_reg < POS_W'(HDR_BYTES)) begin
            if (pos_reg < POS_W'(MARK_BYTES)) begin
                if (s_in_byte != START_MARK[pos_reg[2:0]]) begin
                    start_ok_next = 1'b0;
                end
            end else if (pos_reg < POS_W'(12)) begin
                len_next = {len_reg[23:0], s_in_byte};
            end else begin
                seq_next = seq_cur;
            end

            if (pos_reg != POS_W'(HDR_BYTES - 1)) begin
                pos_next = pos_reg + POS_W'(1);
            end else if (!start_ok_reg) begin
                res_valid     = 1'b1;
                res.kind      = KIND_BAD_START;
                res.seq_warn  = 1'b0;
                res.block_seq = seq_cur;
                res.last      = 1'b1;
            end else if (total > {8'd0, max_block_reg}) begin
                res_valid     = 1'b1;
                res.kind      = KIND_TOO_BIG;
                res.seq_warn  = warn_cur;
                res.block_seq = seq_cur;
                res.last      = 1'b1;
            end else begin
                // header accepted; total fits the limit so it fits POS_W
                warn_next      = warn_cur;
                last_good_next = seq_cur;
                end_start_next = total[POS_W-1:0] - POS_W'(MARK_BYTES);
                last_pos_next  = total[POS_W-1:0] - POS_W'(1);
                pos_next       = POS_W'(HDR_BYTES);
            end
        end else if (pos_reg < end_start_reg) begin
            res_valid        = 1'b1;
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = s_in_byte;
            pos_next         = pos_reg + POS_W'(1);
        end else if (pos_reg >= last_pos_reg) begin
            res_valid = 1'b1;
            res.kind  = end_ok_cur ? KIND_OK : KIND_BAD_END;
            res.last  = 1'b1;
        end else begin
            end_ok_next = end_ok_cur;
            pos_next    = pos_reg + POS_W'(1);
        end

        // any result with last set restarts header hunting
        if (res_valid && res.last) begin
            pos_next       = '0;
            start_ok_next  = 1'b1;
            len_next       = '0;
            seq_next       = '0;
            end_start_next = POS_W'(HDR_BYTES - MARK_BYTES);
            last_pos_next  = POS_W'(HDR_BYTES - 1);
            end_ok_next    = 1'b1;
            warn_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            start_ok_reg  <= 1'b1;
            len_reg       <= '0;
            seq_reg       <= '0;
            end_start_reg <= POS_W'(HDR_BYTES - MARK_BYTES);
            last_pos_reg  <= POS_W'(HDR_BYTES - 1);
            last_good_reg <= '0;
            end_ok_reg    <= 1'b1;
            warn_reg      <= 1'b0;
        end else if (accept) begin
            pos_reg       <= pos_next;
            start_ok_reg  <= start_ok_next;
            len_reg       <= len_next;
            seq_reg       <= seq_next;
            end_start_reg <= end_start_next;
            last_pos_reg  <= last_pos_next;
            last_good_reg <= last_good_next;
            end_ok_reg    <= end_ok_next;
            warn_reg      <= warn_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register with skid stage
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= accept && res_valid;
            end
        end else if (accept && res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end else if (accept && res_valid) begin
            skid_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_kind         = out_reg.kind;
    assign m_payload_byte = out_reg.payload_byte;
    assign m_seq_warn     = out_reg.seq_warn;
    assign m_block_seq    = out_reg.block_seq;
    assign m_last         = out_reg.last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MBD_ASSERT_IMPLY(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `MBD_ASSERT_IMPLY(a_payload_not_last, aclk, aresetn, m_valid && m_kind == KIND_PAYLOAD, !m_last)
    `MBD_ASSERT_IMPLY(a_status_no_data, aclk, aresetn, m_valid && m_kind != KIND_PAYLOAD, m_payload_byte == 8'd0)
    `MBD_ASSERT_IMPLY(a_pos_in_block, aclk, aresetn, pos_reg >= POS_W'(HDR_BYTES), pos_reg <= last_pos_reg)

endmodule
